>>> rtl/core/wbr_pkg.sv
`default_nettype none

package wbr_pkg;

	// Default sizing of the mark store.
	localparam int KEY_SPACE_DEF = 16384;
	localparam int WORD_BITS_DEF = 64;
	localparam int MARK_DEPTH_DEF = (KEY_SPACE_DEF + WORD_BITS_DEF - 1) / WORD_BITS_DEF;

	// Width of the key fields on the ports.
	localparam int KEY_PORT_W = 15;

	typedef enum logic [1:0] {
		OP_MARK  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_BASE,
		ST_RD,
		ST_UPD,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div;
		logic base;
		logic rd;
		logic upd;
		logic step;
		logic clear_all;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic do_clear;
		logic do_walk;
		logic is_query;
		logic last_word;
		logic hit;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/word_bitmap_range_set_and_query.sv
// Handshake: an item is accepted at the edge where start is high and busy is low. A clear,
// an unused opcode or an empty range goes through the word-index state to the done strobe;
// a mark or query over N words adds the base state and a read and an update state per word
// (a query stops at the first word with a hit). The mark memory is a simple dual-port RAM.
// A new item waits until done for the last one has come. Results cannot be stalled.
// Reset: arst_n clears the controller and all per-word valid bits at once; no clearing pass.
`default_nettype none

module word_bitmap_range_set_and_query #(
	parameter int KEY_SPACE = wbr_pkg::KEY_SPACE_DEF,
	parameter int WORD_BITS = wbr_pkg::WORD_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [1:0]                     opcode,
	input  wire logic [wbr_pkg::KEY_PORT_W-1:0] range_begin,
	input  wire logic [wbr_pkg::KEY_PORT_W-1:0] range_end,
	output logic                                done,
	output logic                                conflict
);

	// The controller sequences each item: capture, word-index computation and, for a
	// walk, base computation and alternating read and update cycles per word.
	// The datapath owns the mark memory, its valid bits and the mask logic.
	// A clear only drops the valid bits, so it needs no pass over the words.

	wbr_pkg::dp_cmd_t cmd;
	wbr_pkg::dp_sts_t sts;

	wbr_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// The datapath only latches inputs on the controller's load command, which is
	// issued exactly when an item is accepted.
	wbr_dp #(
		.KEY_SPACE(KEY_SPACE),
		.WORD_BITS(WORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.opcode     (opcode),
		.range_begin(range_begin),
		.range_end  (range_end),
		.sts        (sts),
		.conflict   (conflict)
	);

endmodule

`default_nettype wire

>>> rtl/core/wbr_ram.sv
`default_nettype none

module wbr_ram #(
	parameter int WIDTH = wbr_pkg::WORD_BITS_DEF,
	parameter int DEPTH = wbr_pkg::MARK_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [AW-1:0]          waddr,
	input  wire logic [WIDTH-1:0]       wdata,
	input  wire logic                   re,
	input  wire logic [AW-1:0]          raddr,
	output logic      [WIDTH-1:0]       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/wbr_ctrl.sv
`default_nettype none

module wbr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire wbr_pkg::dp_sts_t  sts,
	output wbr_pkg::dp_cmd_t       cmd,
	output logic                   busy,
	output logic                   done
);

	wbr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wbr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			wbr_pkg::ST_IDLE: begin
				if (start) state_d = wbr_pkg::ST_DIV;
			end
			wbr_pkg::ST_DIV: begin
				state_d = sts.do_walk ? wbr_pkg::ST_BASE : wbr_pkg::ST_DONE;
			end
			wbr_pkg::ST_BASE: state_d = wbr_pkg::ST_RD;
			wbr_pkg::ST_RD:   state_d = wbr_pkg::ST_UPD;
			wbr_pkg::ST_UPD: begin
				if ((sts.is_query && sts.hit) || sts.last_word) begin
					state_d = wbr_pkg::ST_DONE;
				end else begin
					state_d = wbr_pkg::ST_RD;
				end
			end
			wbr_pkg::ST_DONE: state_d = wbr_pkg::ST_IDLE;
			default:          state_d = wbr_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			wbr_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			wbr_pkg::ST_DIV: begin
				cmd.div       = 1'b1;
				cmd.clear_all = sts.do_clear;
			end
			wbr_pkg::ST_BASE: cmd.base = 1'b1;
			wbr_pkg::ST_RD:   cmd.rd   = 1'b1;
			wbr_pkg::ST_UPD: begin
				cmd.upd  = 1'b1;
				cmd.step = !((sts.is_query && sts.hit) || sts.last_word);
			end
			wbr_pkg::ST_DONE: done = 1'b1;
			default:          busy = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/wbr_dp.sv
`default_nettype none

module wbr_dp #(
	parameter int KEY_SPACE = wbr_pkg::KEY_SPACE_DEF,
	parameter int WORD_BITS = wbr_pkg::WORD_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire wbr_pkg::dp_cmd_t               cmd,
	input  wire logic [1:0]                     opcode,
	input  wire logic [wbr_pkg::KEY_PORT_W-1:0] range_begin,
	input  wire logic [wbr_pkg::KEY_PORT_W-1:0] range_end,
	output wbr_pkg::dp_sts_t                    sts,
	output logic                                conflict
);

	localparam int DEPTH = (KEY_SPACE + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int KS_W  = $clog2(KEY_SPACE + 1);
	localparam int CW    = (KS_W > wbr_pkg::KEY_PORT_W) ? KS_W : wbr_pkg::KEY_PORT_W;
	localparam int LW    = $clog2(WORD_BITS);
	// Division by the word size is a multiplication by a rounded-up reciprocal.
	// With this many fraction bits the quotient is exact for every key below 2**CW.
	localparam int SH    = CW + LW + 1;
	localparam int PW    = CW + SH + 1;
	localparam int RECIP = (2 ** SH + WORD_BITS - 1) / WORD_BITS;

	localparam logic [CW-1:0] KEY_C   = CW'(KEY_SPACE);
	localparam logic [CW-1:0] WB_C    = CW'(WORD_BITS);
	localparam logic [PW-1:0] RECIP_C = PW'(RECIP);
	localparam logic [LW:0]   WB_N    = (LW + 1)'(WORD_BITS);

	function automatic logic [WORD_BITS-1:0] low_bits(input logic [LW:0] n);
		logic [WORD_BITS-1:0] ones;
		ones = '1;
		if (n == '0) begin
			return '0;
		end
		return ones >> (WORD_BITS - int'(n));
	endfunction

	logic [1:0]           op_q;
	logic [CW-1:0]        lo_q, hi_q;
	logic [AW-1:0]        w_q, wfirst_q, wlast_q;
	logic [CW-1:0]        base_q;
	logic                 conflict_q;
	logic                 valid_rd_q;
	logic [DEPTH-1:0]     valid_q;

	logic [CW-1:0]        lo_ext, hi_ext, hi_m1;
	logic [PW-1:0]        prod_lo, prod_hi;
	logic [CW-1:0]        first_d, top_d;
	logic [LW:0]          first_n, top_n;
	logic [WORD_BITS-1:0] mask, cur_word, rdata;
	logic                 is_mark, is_query, hit, wr_en;

	assign lo_ext = CW'(range_begin);
	assign hi_ext = CW'(range_end);

	// Input capture with saturation to the key space.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			lo_q <= (lo_ext > KEY_C) ? KEY_C : lo_ext;
			hi_q <= (hi_ext > KEY_C) ? KEY_C : hi_ext;
		end
	end

	assign hi_m1   = hi_q - CW'(1);
	assign prod_lo = PW'(lo_q) * RECIP_C;
	assign prod_hi = PW'(hi_m1) * RECIP_C;

	always_ff @(posedge clk) begin
		if (cmd.div) begin
			wfirst_q <= prod_lo[SH +: AW];
			wlast_q  <= prod_hi[SH +: AW];
		end
		if (cmd.base) begin
			w_q    <= wfirst_q;
			base_q <= CW'(wfirst_q * WB_C);
		end else if (cmd.step) begin
			w_q    <= w_q + AW'(1);
			base_q <= base_q + WB_C;
		end
	end

	assign is_mark  = (op_q == wbr_pkg::OP_MARK);
	assign is_query = (op_q == wbr_pkg::OP_QUERY);

	// Mask of the range's bits inside the current word.
	assign first_d = (lo_q > base_q) ? (lo_q - base_q) : '0;
	assign first_n = first_d[LW:0];
	assign top_d   = hi_q - base_q;
	assign top_n   = (top_d > WB_C) ? WB_N : top_d[LW:0];
	assign mask    = low_bits(top_n) & ~low_bits(first_n);

	// A word that was never written since the last clear reads as zero.
	assign cur_word = valid_rd_q ? rdata : '0;
	assign hit      = |(cur_word & mask);
	assign wr_en    = cmd.upd && is_mark;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_rd_q <= 1'b0;
			conflict_q <= 1'b0;
		end else begin
			if (cmd.clear_all) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[w_q] <= 1'b1;
			end
			if (cmd.rd) begin
				valid_rd_q <= valid_q[w_q];
			end
			if (cmd.load) begin
				conflict_q <= 1'b0;
			end else if (cmd.upd && is_query && hit) begin
				conflict_q <= 1'b1;
			end
		end
	end

	wbr_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(w_q),
		.wdata(cur_word | mask),
		.re   (cmd.rd),
		.raddr(w_q),
		.rdata(rdata)
	);

	assign sts.do_clear  = (op_q == wbr_pkg::OP_CLEAR);
	assign sts.do_walk   = (is_mark || is_query) && (hi_q > lo_q);
	assign sts.is_query  = is_query;
	assign sts.last_word = (w_q == wlast_q);
	assign sts.hit       = hit;

	assign conflict = conflict_q;

endmodule

`default_nettype wire

>>> rtl/core/wbr_checker.sv
`default_nettype none

module wbr_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           start,
	input wire logic                           busy,
	input wire logic [1:0]                     opcode,
	input wire logic [wbr_pkg::KEY_PORT_W-1:0] range_begin,
	input wire logic [wbr_pkg::KEY_PORT_W-1:0] range_end,
	input wire logic                           done,
	input wire logic                           conflict
);

	// A result only appears while an item is in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without busy");

	// An accepted item keeps the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// Busy ends only right after the result strobe.
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without result");

	// Clear and unused opcodes answer quickly with no conflict.
	a_non_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode != wbr_pkg::OP_MARK && opcode != wbr_pkg::OP_QUERY)
		|-> ##2 (done && !conflict))
		else $error("bad result for clear or unused opcode");

	// Only queries may report a conflict, and an empty query never does.
	a_empty_query: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == wbr_pkg::OP_QUERY && range_end <= range_begin)
		|-> ##2 (done && !conflict))
		else $error("empty query reported a conflict");

endmodule

bind word_bitmap_range_set_and_query wbr_checker u_chk (.*);

`default_nettype wire

>>> verif/word_bitmap_range_set_and_query_tb.sv
`timescale 1ns / 1ps

module word_bitmap_range_set_and_query_tb;

	// Sizing of the block under test. These are the defaults the block is built with.
	localparam int KEYS = wbr_pkg::KEY_SPACE_DEF;
	localparam int WB = wbr_pkg::WORD_BITS_DEF;
	localparam int DEPTH = wbr_pkg::MARK_DEPTH_DEF;
	localparam int KEY_W = wbr_pkg::KEY_PORT_W;
	localparam int FIELD_MAX = (1 << KEY_W) - 1;

	// The opcode left free by the package. The block must ignore it and answer no conflict.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS = 600;
	// Longest walk is every word of the store, with a read and an update per word.
	localparam int TAIL_CYCLES = 3 + 2 * DEPTH + 16;

	typedef logic [WB-1:0] word_t;

	// One command item as the sender presents it. The drain flag makes the sender hold
	// this item back until every outstanding result has come in.
	typedef struct {
		logic [1:0] op;
		logic [KEY_W-1:0] key_lo;
		logic [KEY_W-1:0] key_hi;
		bit drain_first;
	} bitmap_cmd_t;

	// A command that has been accepted, together with the conflict bit it must produce.
	typedef struct {
		bitmap_cmd_t cmd;
		logic hit;
	} conflict_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] opcode = '0;
	logic [KEY_W-1:0] range_begin = '0;
	logic [KEY_W-1:0] range_end = '0;
	logic busy;
	logic done;
	logic conflict;

	// Commands still to be sent, and the conflict bits still to be received, oldest first.
	bitmap_cmd_t cmd_q[$];
	conflict_exp_t conflict_exp_q[$];

	// The testbench's own copy of the mark store.
	word_t mark_store [DEPTH];

	int cmd_total = 0;
	int items_accepted = 0;
	int burst_left = 0;
	int gap_left = 0;
	bit holding = 1'b0;
	conflict_exp_t accepted_exp;

	int mismatch_count = 0;
	int results_checked = 0;
	int marks_seen = 0;
	int queries_seen = 0;
	int hits_seen = 0;
	int clears_seen = 0;
	int unused_seen = 0;

	word_bitmap_range_set_and_query i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.range_begin(range_begin),
		.range_end(range_end),
		.done(done),
		.conflict(conflict)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Applies one command to the local mark store and returns the conflict bit the block
	// must answer. Both keys saturate at the top of the key space, so an end key beyond it
	// behaves like the end of the store and a begin key beyond it leaves an empty range.
	// The walk covers the same words as the block, with a partial mask on the first and
	// last word and whole words between them. A query stops at the first word with a hit.
	function automatic logic apply_bitmap_op(input logic [1:0] op,
			input logic [KEY_W-1:0] b, input logic [KEY_W-1:0] e);
		int lo;
		int hi;
		int base;
		int lsb;
		int top;
		word_t mask;
		logic hit;
		lo = (int'(b) > KEYS) ? KEYS : int'(b);
		hi = (int'(e) > KEYS) ? KEYS : int'(e);
		hit = 1'b0;
		if (op == wbr_pkg::OP_CLEAR) begin
			foreach (mark_store[w])
				mark_store[w] = '0;
		end else if ((op == wbr_pkg::OP_MARK || op == wbr_pkg::OP_QUERY) && hi > lo) begin
			for (int w = lo / WB; w <= (hi - 1) / WB && !hit; w++) begin
				base = w * WB;
				lsb = (lo > base) ? lo - base : 0;
				top = (hi - base > WB) ? WB : hi - base;
				mask = (top == WB) ? '1 : ((word_t'(1) << top) - 1'b1);
				mask &= ~((word_t'(1) << lsb) - 1'b1);
				if (op == wbr_pkg::OP_MARK)
					mark_store[w] |= mask;
				else if ((mark_store[w] & mask) != '0)
					hit = 1'b1;
			end
		end
		return hit;
	endfunction

	task automatic queue_cmd(input logic [1:0] op, input int lo, input int hi, input bit drain);
		bitmap_cmd_t c;
		c.op = op;
		c.key_lo = KEY_W'((lo > FIELD_MAX) ? FIELD_MAX : lo);
		c.key_hi = KEY_W'((hi > FIELD_MAX) ? FIELD_MAX : hi);
		c.drain_first = drain;
		cmd_q.insert(cmd_q.size(), c);
		cmd_total++;
	endtask

	// Keys are drawn mostly inside the key space, often on either edge of a word, and now
	// and then above the key space so that the top bit of each key field gets exercised.
	function automatic int pick_key();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			return $urandom_range(KEYS, FIELD_MAX);
		if (sel < 25)
			return $urandom_range(0, DEPTH - 1) * WB + ($urandom_range(0, 1) ? WB - 1 : 0);
		return $urandom_range(0, KEYS);
	endfunction

	task automatic report_mismatch(input string what, input conflict_exp_t e);
		mismatch_count++;
		$display("%0.1f ns: %s (op %0d, range %0d..%0d, conflict %b, predicted %b)",
			$realtime, what, e.cmd.op, e.cmd.key_lo, e.cmd.key_hi, conflict, e.hit);
	endtask

	// Driver. The handshake is sampled at the rising edge: an item is taken when start is
	// high and busy is low. The prediction is made at that very edge, so the local store
	// advances in the same order as the block's. The sender works in bursts of items with
	// idle gaps in between, and an item flagged for draining is held back until every
	// outstanding result has come in. Start gets at most one assignment per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			opcode <= '0;
			range_begin <= '0;
			range_end <= '0;
			foreach (mark_store[w])
				mark_store[w] = '0;
			burst_left = $urandom_range(1, 12);
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				accepted_exp.cmd = cmd_q.pop_front();
				accepted_exp.hit = apply_bitmap_op(accepted_exp.cmd.op, accepted_exp.cmd.key_lo,
					accepted_exp.cmd.key_hi);
				conflict_exp_q.insert(conflict_exp_q.size(), accepted_exp);
				items_accepted++;
				holding = 1'b0;
			end else begin
				holding = start;
			end

			if (holding) begin
				// The item on the ports has not been taken yet; leave it there.
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmd_q.size() == 0) begin
				start <= 1'b0;
			end else if (cmd_q[0].drain_first && conflict_exp_q.size() != 0) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				opcode <= cmd_q[0].op;
				range_begin <= cmd_q[0].key_lo;
				range_end <= cmd_q[0].key_hi;
				if (burst_left <= 1) begin
					// Some bursts run long with no gap, so that items also arrive back to back.
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
						: $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// Monitor. Done and conflict come from registers updated at the rising edge, so they are
	// sampled at the falling edge in the middle of the cycle where done is high. That cycle
	// ends with the rising edge which accepts the result. The queue of predictions is only
	// pushed at rising edges, so the two blocks never touch it in the same step.
	always @(negedge clk) begin
		if (arst_n && done) begin
			if (conflict_exp_q.size() == 0) begin
				accepted_exp.cmd.op = opcode;
				accepted_exp.cmd.key_lo = range_begin;
				accepted_exp.cmd.key_hi = range_end;
				accepted_exp.hit = 1'bx;
				report_mismatch("result strobe with no item outstanding", accepted_exp);
			end else begin
				if (conflict !== conflict_exp_q[0].hit)
					report_mismatch("conflict bit differs", conflict_exp_q[0]);
				results_checked++;
				case (conflict_exp_q[0].cmd.op)
					wbr_pkg::OP_MARK: marks_seen++;
					wbr_pkg::OP_QUERY: begin
						queries_seen++;
						if (conflict_exp_q[0].hit)
							hits_seen++;
					end
					wbr_pkg::OP_CLEAR: clears_seen++;
					default: unused_seen++;
				endcase
				void'(conflict_exp_q.pop_front());
			end
		end
	end

	initial begin
		logic [1:0] op;
		int lo;
		int hi;
		int pick;

		// Directed part. It starts on an empty store, then walks the corners: single keys,
		// a mark across a word boundary, a range of whole words, empty and
		// reversed ranges, keys above the key space that saturate, the unused opcode,
		// clearing, and a mark of the whole store with the end key field at its maximum.
		queue_cmd(wbr_pkg::OP_QUERY, 0, KEYS, 1'b0);
		queue_cmd(wbr_pkg::OP_MARK, 0, 1, 1'b0);
		queue_cmd(wbr_pkg::OP_QUERY, 0, 1, 1'b0);
		queue_cmd(wbr_pkg::OP_QUERY, 1, 2, 1'b0);
		queue_cmd(wbr_pkg::OP_MARK, KEYS - 1, KEYS, 1'b0);
		queue_cmd(wbr_pkg::OP_QUERY, KEYS - 1, FIELD_MAX, 1'b0);
		queue_cmd(wbr_pkg::OP_MARK, KEYS, FIELD_MAX, 1'b0);
		queue_cmd(wbr_pkg::OP_QUERY, KEYS, FIELD_MAX, 1'b0);
		queue_cmd(wbr_pkg::OP_MARK, 100, 100, 1'b0);
		queue_cmd(wbr_pkg::OP_QUERY, 100, 101, 1'b0);
		queue_cmd(wbr_pkg::OP_MARK, 101, 100, 1'b0);
		queue_cmd(wbr_pkg::OP_QUERY, 101, 100, 1'b0);
		queue_cmd(wbr_pkg::OP_MARK, WB - 1, WB + 1, 1'b0);
		queue_cmd(wbr_pkg::OP_QUERY, WB, WB + 1, 1'b0);
		queue_cmd(wbr_pkg::OP_QUERY, WB - 2, WB - 1, 1'b0);
		queue_cmd(wbr_pkg::OP_MARK, 2 * WB, 5 * WB, 1'b0);
		queue_cmd(wbr_pkg::OP_QUERY, 3 * WB + 8, 3 * WB + 9, 1'b0);
		queue_cmd(OP_UNUSED, 0, KEYS, 1'b0);
		queue_cmd(wbr_pkg::OP_CLEAR, FIELD_MAX, FIELD_MAX, 1'b0);
		queue_cmd(wbr_pkg::OP_QUERY, 0, KEYS, 1'b0);
		queue_cmd(wbr_pkg::OP_MARK, 0, FIELD_MAX, 1'b0);
		queue_cmd(wbr_pkg::OP_QUERY, 5000, 5001, 1'b0);
		queue_cmd(wbr_pkg::OP_QUERY, FIELD_MAX, FIELD_MAX, 1'b0);
		queue_cmd(OP_UNUSED, FIELD_MAX, 0, 1'b0);
		queue_cmd(wbr_pkg::OP_CLEAR, 0, 0, 1'b1);

		// Random part. Queries dominate and most ranges cover a few words at most, so that
		// the store fills slowly between the occasional clears and queries answer both
		// ways. A few ranges are long, reversed, or reach beyond the key space. Now and
		// then the sender waits for every outstanding result before going on.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 38)
				op = wbr_pkg::OP_MARK;
			else if (pick < 90)
				op = wbr_pkg::OP_QUERY;
			else if (pick < 95)
				op = wbr_pkg::OP_CLEAR;
			else
				op = OP_UNUSED;
			lo = pick_key();
			pick = $urandom_range(0, 99);
			if (pick < 8)
				hi = pick_key();
			else if (pick < 14)
				hi = lo + $urandom_range(0, KEYS);
			else if (pick < 40)
				hi = lo + $urandom_range(0, 3);
			else
				hi = lo + $urandom_range(0, 150);
			queue_cmd(op, lo, hi, (n == RANDOM_ITEMS / 2) || ($urandom_range(0, 49) == 0));
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (items_accepted != cmd_total)
			@(posedge clk);
		while (conflict_exp_q.size() != 0)
			@(posedge clk);
		// Any stray strobe after the last result shows up within one full walk.
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d marks, %0d queries (%0d answered with a conflict),",
			results_checked, marks_seen, queries_seen, hits_seen);
		$display("%0d clears and %0d unused opcodes, with bursts, gaps and drain pauses.",
			clears_seen, unused_seen);
		if (mismatch_count == 0) begin
			$display("word_bitmap_range_set_and_query: match");
		end else begin
			$display("word_bitmap_range_set_and_query: mismatch");
		end
		$finish;
	end

	// Even if every item walked the whole store a correct run ends before this limit,
	// which only catches a hang or a missing result.
	initial begin
		#20ms;
		$display("Run timed out with %0d results outstanding.", conflict_exp_q.size());
		$display("word_bitmap_range_set_and_query: mismatch");
		$finish;
	end

endmodule
